// ===== design/p31wc_pkg.sv =====
`default_nettype none
package p31wc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned GEN_W    = 31;
    localparam int unsigned IDX_W    = 24;
    localparam int unsigned CNT_W    = 25;
    localparam int unsigned CFG_W    = 25;
    localparam int unsigned CFG_IDX_W = 1;

    // Feedback taps of x^31 + x^28 + 1 as seen from the state register
    localparam int unsigned TAP_HI = 30;
    localparam int unsigned TAP_LO = 27;

    localparam logic [GEN_W-1:0] GEN_SEED = {GEN_W{1'b1}};

    // Largest index the 24-bit word_index field can report, plus one
    localparam int unsigned INDEX_CAP = 32'd16777216;
    localparam int unsigned MAX_WORDS_DEF = 32'd16777216;

    localparam logic [CFG_W-1:0] WORD_LIMIT_RST = 25'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORD_LIMIT  = 1'b0,
        REG_ALIGN_SHIFT = 1'b1
    } t_cfg_reg;

endpackage
`default_nettype wire

// ===== design/p31wc_prbs_step.sv =====
`default_nettype none
module p31wc_prbs_step
    import p31wc_pkg::*;
(
    input  wire logic [GEN_W-1:0]  i_state,
    output logic      [WORD_W-1:0] o_word,
    output logic      [GEN_W-1:0]  o_state
);

    // ext[0..30] hold the state, oldest bit first; ext[31+j] is generated bit j, o_word bit 31-j.
    // Bits up to ext[58] come straight from the state, the last four reuse
    // the first four new bits, so every output is at most three terms deep.
    logic [WORD_W+GEN_W-1:0] ext;

    always_comb begin
        ext = '0;
        for (int i = 0; i < GEN_W; i++) begin
            ext[GEN_W-1-i] = i_state[i];
        end
        for (int j = 0; j < WORD_W; j++) begin
            ext[GEN_W+j] = ext[j + (GEN_W-1-TAP_HI)] ^ ext[j + (GEN_W-1-TAP_LO)];
        end
    end

    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            o_word[WORD_W-1-j] = ext[GEN_W+j];
        end
    end

    // After 32 steps the state is the last 31 generated bits
    assign o_state = o_word[GEN_W-1:0];

endmodule
`default_nettype wire

// ===== design/prbs31_word_checker.sv =====
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the result channel is not stalled; the PRBS register
//   advances 32 bits per compared item through one XOR layer of depth three.
// Reset: synchronous active low; clears the generator to all ones, all counters,
//   the first-error capture, the aligner and the config registers to their defaults.
`default_nettype none
module prbs31_word_checker
    import p31wc_pkg::*;
#(
    parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // input item channel
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [WORD_W-1:0]    i_rx_word,
    // result channel
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_checked,
    output logic                      o_mismatch,
    output logic [IDX_W-1:0]          o_word_index,
    output logic [WORD_W-1:0]         o_expected_word,
    output logic [WORD_W-1:0]         o_error_count,
    output logic                      o_first_error_seen,
    output logic [IDX_W-1:0]          o_first_error_index,
    output logic [WORD_W-1:0]         o_first_error_got,
    output logic [WORD_W-1:0]         o_first_error_expected,
    output logic                      o_capture_done
);

    // Effective word limit ceiling: the smaller of the parameter and the index range
    localparam int unsigned LIM_CAP_I = (MAX_WORDS < INDEX_CAP) ? MAX_WORDS : INDEX_CAP;
    localparam logic [CNT_W-1:0] LIM_CAP = CNT_W'(LIM_CAP_I);

    // configuration
    logic [CFG_W-1:0] r_word_limit;
    logic             r_align;

    // input register
    logic              r_in_valid;
    logic [WORD_W-1:0] r_in_word;

    // checker state
    logic [GEN_W-1:0]  r_gen;
    logic [CNT_W-1:0]  r_chk_cnt;
    logic [CNT_W-1:0]  r_acc_cnt;
    logic [WORD_W-1:0] r_err_tally;
    logic              r_first_seen;
    logic [IDX_W-1:0]  r_first_idx;
    logic [WORD_W-1:0] r_first_got;
    logic [WORD_W-1:0] r_first_exp;
    logic [WORD_W-1:0] r_prev_word;
    logic              r_prev_valid;

    // result register
    logic              r_out_valid;
    logic              r_out_checked;
    logic              r_out_mismatch;
    logic [IDX_W-1:0]  r_out_index;
    logic [WORD_W-1:0] r_out_expected;
    logic              r_out_done;

    // datapath
    logic              advance;
    logic [CNT_W-1:0]  lim;
    logic [CNT_W:0]    cap;
    logic              live;
    logic              chk_ok;
    logic              do_cmp;
    logic [WORD_W-1:0] cmp_word;
    logic [WORD_W-1:0] w_exp;
    logic [GEN_W-1:0]  w_gen_next;
    logic              miss;
    logic [CNT_W-1:0]  n_acc_cnt;
    logic              n_done;

    // Advance the held item whenever the result slot is free or being emptied
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_limit <= WORD_LIMIT_RST;
            r_align      <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_WORD_LIMIT:  r_word_limit <= i_cfg_data;
                REG_ALIGN_SHIFT: r_align      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_word <= i_rx_word;
        end
    end

    p31wc_prbs_step u_step (
        .i_state (r_gen),
        .o_word  (w_exp),
        .o_state (w_gen_next)
    );

    always_comb begin
        lim    = (r_word_limit > LIM_CAP) ? LIM_CAP : r_word_limit;
        cap    = {1'b0, lim} + (CNT_W+1)'(r_align);
        live   = {1'b0, r_acc_cnt} < cap;
        chk_ok = r_chk_cnt < lim;
        // In align mode the first raw word only primes the aligner
        do_cmp = live && chk_ok && (!r_align || r_prev_valid);
        cmp_word = r_align ? {r_prev_word[WORD_W-2:0], r_in_word[WORD_W-1]} : r_in_word;
        miss   = do_cmp && (cmp_word != w_exp);
        n_acc_cnt = live ? r_acc_cnt + CNT_W'(1) : r_acc_cnt;
        n_done = {1'b0, n_acc_cnt} >= cap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen        <= GEN_SEED;
            r_chk_cnt    <= '0;
            r_acc_cnt    <= '0;
            r_err_tally  <= '0;
            r_first_seen <= 1'b0;
            r_first_idx  <= '0;
            r_first_got  <= '0;
            r_first_exp  <= '0;
            r_prev_word  <= '0;
            r_prev_valid <= 1'b0;
        end else if (advance) begin
            r_acc_cnt <= n_acc_cnt;
            if (live && r_align) begin
                r_prev_word  <= r_in_word;
                r_prev_valid <= 1'b1;
            end
            if (do_cmp) begin
                r_gen     <= w_gen_next;
                r_chk_cnt <= r_chk_cnt + CNT_W'(1);
            end
            if (miss) begin
                // Saturate the tally at all ones
                if (r_err_tally != '1) begin
                    r_err_tally <= r_err_tally + WORD_W'(1);
                end
                if (!r_first_seen) begin
                    r_first_seen <= 1'b1;
                    r_first_idx  <= r_chk_cnt[IDX_W-1:0];
                    r_first_got  <= cmp_word;
                    r_first_exp  <= w_exp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_checked  <= do_cmp;
            r_out_mismatch <= miss;
            r_out_index    <= do_cmp ? r_chk_cnt[IDX_W-1:0] : '0;
            r_out_expected <= do_cmp ? w_exp : '0;
            r_out_done     <= n_done;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_checked              = r_out_checked;
    assign o_mismatch             = r_out_mismatch;
    assign o_word_index           = r_out_index;
    assign o_expected_word        = r_out_expected;
    assign o_capture_done         = r_out_done;
    // Running state only moves when a new result enters the result register,
    // so it always matches the result on display
    assign o_error_count          = r_err_tally;
    assign o_first_error_seen     = r_first_seen;
    assign o_first_error_index    = r_first_idx;
    assign o_first_error_got      = r_first_got;
    assign o_first_error_expected = r_first_exp;

endmodule
`default_nettype wire

// ===== design/p31wc_checker.sv =====
`default_nettype none
module p31wc_checker
    import p31wc_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic              o_checked,
    input wire logic              o_mismatch,
    input wire logic [IDX_W-1:0]  o_word_index,
    input wire logic [WORD_W-1:0] o_expected_word,
    input wire logic [WORD_W-1:0] o_error_count,
    input wire logic              o_first_error_seen
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_expected_word) && $stable(o_word_index))
        else $error("result changed while stalled");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_checked |-> !o_mismatch && o_word_index == '0 && o_expected_word == '0)
        else $error("fields set on an item without comparison");

    a_miss_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mismatch |-> o_first_error_seen && o_error_count != '0)
        else $error("mismatch without recorded error");

    a_count_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_error_count != '0) == o_first_error_seen))
        else $error("error count and first error flag disagree");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready ##1 o_valid |-> o_error_count >= $past(o_error_count))
        else $error("error count went down");

endmodule

bind prbs31_word_checker p31wc_checker u_p31wc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_checked          (o_checked),
    .o_mismatch         (o_mismatch),
    .o_word_index       (o_word_index),
    .o_expected_word    (o_expected_word),
    .o_error_count      (o_error_count),
    .o_first_error_seen (o_first_error_seen)
);
`default_nettype wire

// ===== tb/prbs31_result_checker.sv =====
`timescale 1ns / 1ps

module prbs31_result_checker
    import p31wc_pkg::*;
#(
    parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic [WORD_W-1:0]    i_rx_word,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic                 i_checked,
    input  wire logic                 i_mismatch,
    input  wire logic [IDX_W-1:0]     i_word_index,
    input  wire logic [WORD_W-1:0]    i_expected_word,
    input  wire logic [WORD_W-1:0]    i_error_count,
    input  wire logic                 i_first_error_seen,
    input  wire logic [IDX_W-1:0]     i_first_error_index,
    input  wire logic [WORD_W-1:0]    i_first_error_got,
    input  wire logic [WORD_W-1:0]    i_first_error_expected,
    input  wire logic                 i_capture_done,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic              checked;
        logic              mismatch;
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] expected_word;
        logic [WORD_W-1:0] error_count;
        logic              first_error_seen;
        logic [IDX_W-1:0]  first_error_index;
        logic [WORD_W-1:0] first_error_got;
        logic [WORD_W-1:0] first_error_expected;
        logic              capture_done;
    } prbs_verdict_t;

    prbs_verdict_t prbs_verdicts_q[$];

    logic [CFG_W-1:0]  limit_reg;
    logic              align_reg;
    logic [GEN_W-1:0]  gen_state;
    logic [CNT_W-1:0]  words_compared;
    logic [CNT_W-1:0]  words_taken;
    logic [WORD_W-1:0] err_total;
    logic              first_hit;
    logic [IDX_W-1:0]  first_idx;
    logic [WORD_W-1:0] first_got;
    logic [WORD_W-1:0] first_exp;
    logic [WORD_W-1:0] last_raw;
    logic              last_raw_ok;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // 32 generator steps, first bit lands in bit 31; the next state is the
    // last 31 bits produced, i.e. the low bits of the word
    function automatic logic [WORD_W-1:0] prbs_word(input logic [GEN_W-1:0] seed);
        logic [GEN_W-1:0]  s;
        logic [WORD_W-1:0] w;
        logic              nb;
        s = seed;
        w = '0;
        for (int i = 0; i < WORD_W; i++) begin
            nb = s[TAP_HI] ^ s[TAP_LO];
            s  = {s[GEN_W-2:0], nb};
            w  = {w[WORD_W-2:0], nb};
        end
        return w;
    endfunction

    task automatic note_failure(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    task automatic predict_prbs_verdict(input logic [WORD_W-1:0] rx);
        int unsigned   lim_u;
        logic [CNT_W-1:0] lim;
        logic [CNT_W:0]   cap;
        logic [WORD_W-1:0] cmp_word;
        logic          do_cmp;
        prbs_verdict_t v;
        lim_u = 32'(limit_reg);
        if (lim_u > MAX_WORDS) lim_u = MAX_WORDS;
        if (lim_u > INDEX_CAP) lim_u = INDEX_CAP;
        lim      = lim_u[CNT_W-1:0];
        cap      = {1'b0, lim} + (CNT_W+1)'(align_reg);
        v        = '0;
        do_cmp   = 1'b0;
        cmp_word = rx;
        if ({1'b0, words_taken} < cap) begin
            if (align_reg) begin
                if (last_raw_ok && words_compared < lim) begin
                    cmp_word = {last_raw[WORD_W-2:0], rx[WORD_W-1]};
                    do_cmp   = 1'b1;
                end
                last_raw    = rx;
                last_raw_ok = 1'b1;
            end else if (words_compared < lim) begin
                do_cmp = 1'b1;
            end
            if (do_cmp) begin
                v.checked       = 1'b1;
                v.word_index    = words_compared[IDX_W-1:0];
                v.expected_word = prbs_word(gen_state);
                gen_state       = v.expected_word[GEN_W-1:0];
                if (cmp_word != v.expected_word) begin
                    v.mismatch = 1'b1;
                    if (!first_hit) begin
                        first_hit = 1'b1;
                        first_idx = v.word_index;
                        first_got = cmp_word;
                        first_exp = v.expected_word;
                    end
                    if (err_total != '1) err_total++;
                end
                words_compared++;
            end
            words_taken++;
        end
        v.error_count          = err_total;
        v.first_error_seen     = first_hit;
        v.first_error_index    = first_idx;
        v.first_error_got      = first_got;
        v.first_error_expected = first_exp;
        v.capture_done         = ({1'b0, words_taken} >= cap);
        prbs_verdicts_q.push_back(v);
    endtask

    task automatic compare_verdict();
        prbs_verdict_t want;
        if (prbs_verdicts_q.size() == 0) begin
            note_failure("unexpected result", 32'h0, {8'h0, i_word_index});
        end else begin
            want = prbs_verdicts_q.pop_front();
            if (i_checked != want.checked)
                note_failure("checked", 32'(want.checked), 32'(i_checked));
            if (i_mismatch != want.mismatch)
                note_failure("mismatch", 32'(want.mismatch), 32'(i_mismatch));
            if (i_word_index != want.word_index)
                note_failure("word_index", 32'(want.word_index), 32'(i_word_index));
            if (i_expected_word != want.expected_word)
                note_failure("expected_word", want.expected_word, i_expected_word);
            if (i_error_count != want.error_count)
                note_failure("error_count", want.error_count, i_error_count);
            if (i_first_error_seen != want.first_error_seen)
                note_failure("first_error_seen", 32'(want.first_error_seen),
                             32'(i_first_error_seen));
            if (i_first_error_index != want.first_error_index)
                note_failure("first_error_index", 32'(want.first_error_index),
                             32'(i_first_error_index));
            if (i_first_error_got != want.first_error_got)
                note_failure("first_error_got", want.first_error_got, i_first_error_got);
            if (i_first_error_expected != want.first_error_expected)
                note_failure("first_error_expected", want.first_error_expected,
                             i_first_error_expected);
            if (i_capture_done != want.capture_done)
                note_failure("capture_done", 32'(want.capture_done), 32'(i_capture_done));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_reg      = WORD_LIMIT_RST;
            align_reg      = 1'b0;
            gen_state      = GEN_SEED;
            words_compared = '0;
            words_taken    = '0;
            err_total      = '0;
            first_hit      = 1'b0;
            first_idx      = '0;
            first_got      = '0;
            first_exp      = '0;
            last_raw       = '0;
            last_raw_ok    = 1'b0;
            prbs_verdicts_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_WORD_LIMIT:  limit_reg = i_cfg_data;
                    REG_ALIGN_SHIFT: align_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready)
                compare_verdict();
            if (i_in_valid && i_in_ready)
                predict_prbs_verdict(i_rx_word);
        end
        o_pending <= prbs_verdicts_q.size();
    end

endmodule

// ===== tb/prbs31_word_checker_test.sv =====
`timescale 1ns / 1ps

module prbs31_word_checker_test;
    import p31wc_pkg::*;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_WORD_LIMIT;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic [WORD_W-1:0]    i_rx_word   = '0;
    logic                 i_ready     = 1'b0;

    logic                 o_ready;
    logic                 o_valid;
    logic                 o_checked;
    logic                 o_mismatch;
    logic [IDX_W-1:0]     o_word_index;
    logic [WORD_W-1:0]    o_expected_word;
    logic [WORD_W-1:0]    o_error_count;
    logic                 o_first_error_seen;
    logic [IDX_W-1:0]     o_first_error_index;
    logic [WORD_W-1:0]    o_first_error_got;
    logic [WORD_W-1:0]    o_first_error_expected;
    logic                 o_capture_done;

    int fail_count;
    int pending;

    // Idle percentages for the two sides; changed only between phases
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;

    // Long receiver hold-off, timed by its own process
    event start_long_hold;
    logic long_hold = 1'b0;

    // Stimulus-side view of where the block's generator and counters stand,
    // used only to shape well-formed streams (the checker does the predicting)
    logic [GEN_W-1:0] stream_gen  = GEN_SEED;
    logic [CFG_W-1:0] stream_lim  = WORD_LIMIT_RST;
    logic             stream_algn = 1'b0;
    logic [CNT_W-1:0] stream_chk  = '0;
    logic [CNT_W-1:0] stream_acc  = '0;
    logic             stream_prev = 1'b0;

    prbs31_word_checker dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_rx_word              (i_rx_word),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_checked              (o_checked),
        .o_mismatch             (o_mismatch),
        .o_word_index           (o_word_index),
        .o_expected_word        (o_expected_word),
        .o_error_count          (o_error_count),
        .o_first_error_seen     (o_first_error_seen),
        .o_first_error_index    (o_first_error_index),
        .o_first_error_got      (o_first_error_got),
        .o_first_error_expected (o_first_error_expected),
        .o_capture_done         (o_capture_done)
    );

    prbs31_result_checker u_result_check (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_valid),
        .i_in_ready             (o_ready),
        .i_rx_word              (i_rx_word),
        .i_out_valid            (o_valid),
        .i_out_ready            (i_ready),
        .i_checked              (o_checked),
        .i_mismatch             (o_mismatch),
        .i_word_index           (o_word_index),
        .i_expected_word        (o_expected_word),
        .i_error_count          (o_error_count),
        .i_first_error_seen     (o_first_error_seen),
        .i_first_error_index    (o_first_error_index),
        .i_first_error_got      (o_first_error_got),
        .i_first_error_expected (o_first_error_expected),
        .i_capture_done         (o_capture_done),
        .o_fail_count           (fail_count),
        .o_pending              (pending)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: stall at the current rate, and drop ready entirely during a long hold
    always @(posedge i_clk) begin
        i_ready <= !long_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    always begin
        @(start_long_hold);
        long_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // Stimulus generator of its own: 32 steps of x^31 + x^28 + 1, first bit in bit 31
    function automatic logic [WORD_W-1:0] stream_word(input logic [GEN_W-1:0] seed);
        logic [GEN_W-1:0]  s;
        logic [WORD_W-1:0] w;
        logic              nb;
        s = seed;
        w = '0;
        for (int i = 0; i < WORD_W; i++) begin
            nb = s[TAP_HI] ^ s[TAP_LO];
            s  = {s[GEN_W-2:0], nb};
            w  = {w[WORD_W-2:0], nb};
        end
        return w;
    endfunction

    // Offer one item and hold it until the block takes it; insert random gaps first
    task automatic offer_word(input logic [WORD_W-1:0] w);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_word <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Build the next item of a clean stream, then corrupt it as asked.
    // In realign mode each raw item carries the last bit of the word it
    // completes and the top 31 bits of the word after it.
    task automatic send_stream_word(input logic [WORD_W-1:0] flip, input bit replace,
                                    input logic [WORD_W-1:0] value);
        int unsigned       lim_u;
        logic [CNT_W-1:0]  lim;
        logic [CNT_W:0]    cap;
        logic [WORD_W-1:0] pa;
        logic [WORD_W-1:0] pb;
        logic [WORD_W-1:0] raw;
        logic              coin;
        lim_u = 32'(stream_lim);
        if (lim_u > INDEX_CAP) lim_u = INDEX_CAP;
        lim  = lim_u[CNT_W-1:0];
        cap  = {1'b0, lim} + (CNT_W+1)'(stream_algn);
        pa   = stream_word(stream_gen);
        pb   = stream_word(pa[GEN_W-1:0]);
        coin = 1'($urandom_range(1));
        raw  = pa;
        if ({1'b0, stream_acc} < cap) begin
            if (stream_algn) begin
                if (stream_prev && stream_chk < lim) begin
                    raw        = {pa[0], pb[WORD_W-1:1]};
                    stream_gen = pa[GEN_W-1:0];
                    stream_chk++;
                end else begin
                    // priming item: only its low 31 bits matter
                    raw = {coin, pa[WORD_W-1:1]};
                end
                stream_prev = 1'b1;
            end else if (stream_chk < lim) begin
                stream_gen = pa[GEN_W-1:0];
                stream_chk++;
            end
            stream_acc++;
        end
        if (replace) raw = value;
        offer_word(raw ^ flip);
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_regs(input logic [CFG_W-1:0] limit, input logic align);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_WORD_LIMIT;
        i_cfg_data  <= limit;
        @(posedge i_clk);
        i_cfg_index <= REG_ALIGN_SHIFT;
        i_cfg_data  <= {{(CFG_W-1){1'b0}}, align};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        stream_lim  = limit;
        stream_algn = align;
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Mostly clean stream with random bit errors and some garbage words
    task automatic random_words(input int count);
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_stream_word(32'h1 << $urandom_range(31), 1'b0, '0);
            else if (pick < 10)
                send_stream_word($urandom, 1'b0, '0);
            else if (pick < 14)
                send_stream_word('0, 1'b1, $urandom);
            else
                send_stream_word('0, 1'b0, '0);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: out-of-range limit clamps, so every word is compared
        src_idle_pct   = 15;
        sink_stall_pct = 15;
        set_regs(25'h1FF_FFFF, 1'b0);
        send_stream_word('0, 1'b0, '0);
        send_stream_word('0, 1'b0, '0);
        send_stream_word('0, 1'b1, 32'h0000_0000);
        send_stream_word('0, 1'b1, 32'hFFFF_FFFF);
        send_stream_word(32'hFFFF_FFFF, 1'b0, '0);
        send_stream_word(32'h8000_0000, 1'b0, '0);
        send_stream_word(32'h0000_0001, 1'b0, '0);
        send_stream_word('0, 1'b0, '0);
        drain_results();

        // Short limit: three more compares, then words are ignored and capture ends
        set_regs(stream_chk + 25'd3, 1'b0);
        repeat (5) send_stream_word('0, 1'b0, '0);
        drain_results();

        // Realign mode: one priming word, three compares (one corrupted), one ignored
        set_regs(stream_chk + 25'd3, 1'b1);
        send_stream_word('0, 1'b0, '0);
        send_stream_word('0, 1'b0, '0);
        send_stream_word(32'h0001_0000, 1'b0, '0);
        send_stream_word('0, 1'b0, '0);
        send_stream_word('0, 1'b0, '0);
        drain_results();

        // Zero and minimum limits: nothing more can be compared
        set_regs('0, 1'b1);
        send_stream_word('0, 1'b0, '0);
        drain_results();
        set_regs(25'd1, 1'b0);
        send_stream_word('0, 1'b0, '0);
        drain_results();

        // Random part at the largest limit, every idling mix, alternating alignment
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
                default: begin src_idle_pct = 15; sink_stall_pct = 15; end
            endcase
            for (int algn = 0; algn < 2; algn++) begin
                set_regs(25'h100_0000, algn[0]);
                random_words(50);
                drain_results();
            end
        end

        // Back-pressure: hold the receiver off while the sender keeps offering
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_regs(25'h100_0000, 1'b0);
        -> start_long_hold;
        random_words(40);
        drain_results();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hang guard: a correct run needs well under a tenth of this
    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
design/p31wc_pkg.sv
design/p31wc_prbs_step.sv
design/prbs31_word_checker.sv
design/p31wc_checker.sv
tb/prbs31_result_checker.sv
tb/prbs31_word_checker_test.sv
